// ----- hw/rtl/rmss_pkg.sv -----
// ----------------------------------------------------------------------------
// rmss_pkg
// Shared types, codes and field layout for the range max-subarray-sum block.
// ----------------------------------------------------------------------------
package rmss_pkg;

   localparam int IDX_W   = 11;
   localparam int ELEM_W  = 16;
   localparam int SUM_W   = 32;
   localparam int FUNC_W  = 2;

   // request tdata layout, lowest bit first
   localparam int EIDX_LSB   = 0;
   localparam int EVAL_LSB   = EIDX_LSB + IDX_W;
   localparam int RLEFT_LSB  = EVAL_LSB + ELEM_W;
   localparam int RRIGHT_LSB = RLEFT_LSB + IDX_W;
   localparam int REQ_BITS   = RRIGHT_LSB + IDX_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_REG_LENGTH = 1'b0;
   localparam logic [IDX_W-1:0] LENGTH_RESET = 11'd1024;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_BUILD = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef struct packed {
      logic signed [SUM_W-1:0] total;
      logic signed [SUM_W-1:0] best;
      logic signed [SUM_W-1:0] prefix;
      logic signed [SUM_W-1:0] suffix;
   } node_type;

   localparam int NODE_W = 4 * SUM_W;

endpackage

// ----- hw/rtl/rmss_ram.sv -----
// ----------------------------------------------------------------------------
// rmss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmss_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rmss_merge.sv -----
// ----------------------------------------------------------------------------
// rmss_merge
// Merge of two adjacent segment summaries (left a, right b).
// ----------------------------------------------------------------------------
module rmss_merge (
   input  rmss_pkg::node_type a,
   input  rmss_pkg::node_type b,
   output rmss_pkg::node_type r
);
   import rmss_pkg::*;

   logic signed [SUM_W-1:0] cross_sum;
   logic signed [SUM_W-1:0] pre_ext;
   logic signed [SUM_W-1:0] suf_ext;
   logic signed [SUM_W-1:0] best_side;

   always_comb begin
      cross_sum = a.suffix + b.prefix;
      pre_ext   = a.total + b.prefix;
      suf_ext   = a.suffix + b.total;
      best_side = (a.best > b.best) ? a.best : b.best;
      r.total   = a.total + b.total;
      r.best    = (best_side > cross_sum) ? best_side : cross_sum;
      r.prefix  = (a.prefix > pre_ext) ? a.prefix : pre_ext;
      r.suffix  = (b.suffix > suf_ext) ? b.suffix : suf_ext;
   end

endmodule

// ----- hw/rtl/range_max_subarray_sum_top.sv -----
// ----------------------------------------------------------------------------
// range_max_subarray_sum_top
// Segment tree of signed elements answering max contiguous subarray sums.
// ----------------------------------------------------------------------------
// Load: the element is written when the request is accepted; the block stays ready.
// Build: post-order walk, bound by the single node RAM read port and the
//   shared merge unit.
// Query: visits up to about 4 nodes per tree level.
// Reset: element store is cleared to zero, with no item taken until the clear
//   completes; length register returns to 1024. Node store is undefined until built.
module range_max_subarray_sum_top #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [10:0] element_index, [26:11] element_value, [37:27] range_left,
   // [48:38] range_right, rest zero
   input  logic [rmss_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] func
   input  logic [rmss_pkg::FUNC_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] max_sum
   output logic [rmss_pkg::SUM_W-1:0]          rsp_tdata,
   // [0] status
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rmss_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rmss_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rmss_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import rmss_pkg::*;

   localparam int EAW    = $clog2(MAX_ELEMENTS);
   localparam int NDEPTH = 4 * MAX_ELEMENTS;
   localparam int NAW    = $clog2(NDEPTH);
   localparam int LVLS   = $clog2(MAX_ELEMENTS) + 1;
   localparam int LVW    = (LVLS > 1) ? $clog2(LVLS) : 1;

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_VISIT  = 9'b000000100,
      ST_LEAF   = 9'b000001000,
      ST_ACC    = 9'b000010000,
      ST_ASCEND = 9'b000100000,
      ST_KID    = 9'b001000000,
      ST_MERGE  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [EAW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [IDX_W-1:0] len_ff, len_in;
   logic             build_ff, build_in;
   logic [NAW-1:0]   k_ff, k_in;
   logic [LVW-1:0]   lvl_ff, lvl_in;
   logic [IDX_W-1:0] cur_lo_ff, cur_lo_in, cur_hi_ff, cur_hi_in;
   logic [IDX_W-1:0] ql_ff, ql_in, qr_ff, qr_in;
   node_type         acc_ff, acc_in, left_ff, left_in;
   logic             acc_vld_ff, acc_vld_in;
   logic [SUM_W-1:0] res_sum_ff, res_sum_in;
   logic             res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic             rsp_status_ff, rsp_status_in;

   logic [IDX_W-1:0] lo_stk_ff  [LVLS];
   logic [IDX_W-1:0] hi_stk_ff  [LVLS];
   logic [IDX_W-1:0] rhi_stk_ff [LVLS];
   logic             push;

   logic              elem_wr_en, elem_rd_en;
   logic [EAW-1:0]    elem_wr_addr, elem_rd_addr;
   logic [ELEM_W-1:0] elem_wr_data, elem_rd_data;
   logic              node_wr_en, node_rd_en;
   logic [NAW-1:0]    node_wr_addr, node_rd_addr;
   node_type          node_wr_data, node_rd;
   logic [NODE_W-1:0] node_rd_bits;

   node_type merge_a, merge_r;

   logic [IDX_W-1:0] f_idx, f_left, f_right, n_eff;
   logic [ELEM_W-1:0] f_val;
   logic [IDX_W:0]   span_sum;
   logic [IDX_W-1:0] mid;
   logic             req_acc, cfg_wr;

   assign f_idx   = req_tdata[EIDX_LSB +: IDX_W];
   assign f_val   = req_tdata[EVAL_LSB +: ELEM_W];
   assign f_left  = req_tdata[RLEFT_LSB +: IDX_W];
   assign f_right = req_tdata[RRIGHT_LSB +: IDX_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // config port
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[CSR_ADDR_W-1] == CSR_REG_LENGTH);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_REG_LENGTH) ?
                       CSR_DATA_W'(len_ff) : '0;

   always_comb begin
      if (len_ff == '0) begin
         n_eff = IDX_W'(1);
      end else if (32'(len_ff) > 32'(MAX_ELEMENTS)) begin
         n_eff = IDX_W'(MAX_ELEMENTS);
      end else begin
         n_eff = len_ff;
      end
   end

   assign span_sum = {1'b0, cur_lo_ff} + {1'b0, cur_hi_ff};
   assign mid      = span_sum[IDX_W:1];
   assign node_rd  = node_type'(node_rd_bits);
   assign merge_a  = (state_ff == ST_ACC) ? acc_ff : left_ff;

   rmss_merge u_merge (
      .a (merge_a),
      .b (node_rd),
      .r (merge_r)
   );

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      len_in        = cfg_wr ? csr_pwdata[IDX_W-1:0] : len_ff;
      build_in      = build_ff;
      k_in          = k_ff;
      lvl_in        = lvl_ff;
      cur_lo_in     = cur_lo_ff;
      cur_hi_in     = cur_hi_ff;
      ql_in         = ql_ff;
      qr_in         = qr_ff;
      acc_in        = acc_ff;
      acc_vld_in    = acc_vld_ff;
      left_in       = left_ff;
      res_sum_in    = res_sum_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      push          = 1'b0;
      elem_wr_en    = 1'b0;
      elem_wr_addr  = EAW'(f_idx - 1'b1);
      elem_wr_data  = f_val;
      elem_rd_en    = 1'b0;
      elem_rd_addr  = EAW'(cur_lo_ff - 1'b1);
      node_wr_en    = 1'b0;
      node_wr_addr  = k_ff;
      node_wr_data  = merge_r;
      node_rd_en    = 1'b0;
      node_rd_addr  = k_ff;

      case (state_ff)
         ST_CLEAR: begin
            elem_wr_en   = 1'b1;
            elem_wr_addr = clr_cnt_ff;
            elem_wr_data = '0;
            if (clr_cnt_ff == EAW'(MAX_ELEMENTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               k_in      = NAW'(1);
               lvl_in    = '0;
               cur_lo_in = IDX_W'(1);
               cur_hi_in = n_eff;
               case (func_type'(req_tuser))
                  FUNC_LOAD: begin
                     elem_wr_en = (f_idx != '0) &&
                                  (32'(f_idx) <= 32'(MAX_ELEMENTS));
                  end
                  FUNC_BUILD: begin
                     build_in = 1'b1;
                     state_in = ST_VISIT;
                  end
                  FUNC_QUERY: begin
                     build_in   = 1'b0;
                     ql_in      = f_left;
                     qr_in      = f_right;
                     acc_vld_in = 1'b0;
                     if (f_left == '0 || f_left > f_right || f_right > n_eff) begin
                        res_sum_in    = '0;
                        res_status_in = STATUS_BAD;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_VISIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_VISIT: begin
            if (build_ff && cur_lo_ff == cur_hi_ff) begin
               elem_rd_en = 1'b1;
               state_in   = ST_LEAF;
            end else if (!build_ff && (cur_lo_ff > qr_ff || cur_hi_ff < ql_ff)) begin
               state_in = ST_ASCEND;
            end else if (!build_ff && cur_lo_ff >= ql_ff && cur_hi_ff <= qr_ff) begin
               node_rd_en = 1'b1;
               state_in   = ST_ACC;
            end else begin
               // descend to the left child
               push      = 1'b1;
               lvl_in    = lvl_ff + 1'b1;
               k_in      = {k_ff[NAW-2:0], 1'b0};
               cur_hi_in = mid;
            end
         end
         ST_LEAF: begin
            node_wr_en          = 1'b1;
            node_wr_data.total  = {{(SUM_W-ELEM_W){elem_rd_data[ELEM_W-1]}}, elem_rd_data};
            node_wr_data.best   = node_wr_data.total;
            node_wr_data.prefix = node_wr_data.total;
            node_wr_data.suffix = node_wr_data.total;
            state_in            = ST_ASCEND;
         end
         ST_ACC: begin
            acc_in     = acc_vld_ff ? merge_r : node_rd;
            acc_vld_in = 1'b1;
            state_in   = ST_ASCEND;
         end
         ST_ASCEND: begin
            if (lvl_ff == '0) begin
               if (build_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  res_sum_in    = acc_ff.best;
                  res_status_in = STATUS_OK;
                  state_in      = ST_DONE;
               end
            end else if (!k_ff[0]) begin
               // left child done: move to its sibling
               k_in      = k_ff + 1'b1;
               cur_lo_in = cur_hi_ff + 1'b1;
               cur_hi_in = rhi_stk_ff[lvl_ff];
               state_in  = ST_VISIT;
            end else begin
               lvl_in    = lvl_ff - 1'b1;
               k_in      = {1'b0, k_ff[NAW-1:1]};
               cur_lo_in = lo_stk_ff[lvl_ff - 1'b1];
               cur_hi_in = hi_stk_ff[lvl_ff - 1'b1];
               if (build_ff) begin
                  node_rd_en   = 1'b1;
                  node_rd_addr = k_ff - 1'b1;
                  state_in     = ST_KID;
               end
            end
         end
         ST_KID: begin
            left_in      = node_rd;
            node_rd_en   = 1'b1;
            node_rd_addr = {k_ff[NAW-2:0], 1'b1};
            state_in     = ST_MERGE;
         end
         ST_MERGE: begin
            node_wr_en = 1'b1;
            state_in   = ST_ASCEND;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_sum_in    = res_sum_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         len_ff       <= LENGTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      build_ff      <= build_in;
      k_ff          <= k_in;
      lvl_ff        <= lvl_in;
      cur_lo_ff     <= cur_lo_in;
      cur_hi_ff     <= cur_hi_in;
      ql_ff         <= ql_in;
      qr_ff         <= qr_in;
      acc_ff        <= acc_in;
      acc_vld_ff    <= acc_vld_in;
      left_ff       <= left_in;
      res_sum_ff    <= res_sum_in;
      res_status_ff <= res_status_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
      if (push) begin
         lo_stk_ff[lvl_ff]          <= cur_lo_ff;
         hi_stk_ff[lvl_ff]          <= cur_hi_ff;
         rhi_stk_ff[lvl_ff + 1'b1]  <= cur_hi_ff;
      end
   end

   rmss_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_en   (elem_rd_en),
      .rd_addr (elem_rd_addr),
      .rd_data (elem_rd_data)
   );

   rmss_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NDEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_bits)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sum_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_clear_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready)
      else $error("item taken during element clear");

   a_bad_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_BAD |-> rsp_tdata == '0)
      else $error("bad-range result with nonzero sum");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE && state_ff != ST_CLEAR |-> 32'(lvl_ff) < LVLS)
      else $error("tree walk deeper than stack");

   a_merge_after_kid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> $past(state_ff) == ST_KID)
      else $error("merge without child reads");

endmodule
